@@ sv/i2c_fts_pkg.sv @@
// types and constants shared by the framed-transfer sequencer modules
// no dependencies

package i2c_fts_pkg;

   // input item kinds as they arrive on the request port
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   // queue depth between front and back, and its pointer width
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   // classified operation carried through the queue
   typedef enum logic [1:0] {
      OP_NOP,
      OP_LOAD,
      OP_START,
      OP_EVENT
   } op_type;

   // bus commands
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_RESTART = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_SEND    = 3'd4,
      CMD_CLOCK   = 3'd5,
      CMD_ACK     = 3'd6
   } cmd_type;

   // sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ADDR     = 4'd1,
      PH_LEN      = 4'd2,
      PH_DATA     = 4'd3,
      PH_CHK      = 4'd4,
      PH_SENT     = 4'd5,
      PH_RXSTART  = 4'd6,
      PH_RXLEN    = 4'd7,
      PH_RXDATA   = 4'd8,
      PH_RXCHK    = 4'd9,
      PH_WAITSTOP = 4'd10,
      PH_DONE     = 4'd11
   } phase_type;

   // one classified item in the queue
   typedef struct packed {
      op_type     op;
      logic [7:0] tx_byte;
      logic [7:0] slave_addr;
      logic [5:0] tx_count;
      logic [7:0] rx_size;
      logic       arb_lost;
      logic       acked;
      logic [7:0] rx_byte;
   } item_type;

   // one result item
   typedef struct packed {
      cmd_type    bus_cmd;
      logic [7:0] cmd_byte;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [7:0] rx_index;
      logic       done_res;
      logic       check_error;
      logic [7:0] rx_total;
   } result_type;

endpackage

@@ sv/i2c_framed_transfer_sequencer.sv @@
// top level of the framed-transfer sequencer for an i2c master
// depends on i2c_fts_pkg, i2c_fts_front, i2c_fts_queue and i2c_fts_back

// Accepts one request item per clock while req_stall is low and returns exactly
// one response item for each, in order. A request is classified on arrival and
// enters a two-entry queue; the sequencer takes one item from the queue per
// cycle while rsp_stall is low and places its response in an output register,
// so a response passes through the queue and then the output register; the
// sustained rate is one item per cycle while rsp_stall stays low. The rate is
// set by the sequencer step and the one registered read port of the transmit
// store, which is fetched ahead of use. Transmit bytes are loaded before a
// start item; the store holds TX_DEPTH bytes and further loads are dropped.

module i2c_framed_transfer_sequencer
   import i2c_fts_pkg::*;
#(
   parameter int TX_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_tx_byte,
   input  logic [7:0] req_slave_addr,
   input  logic [5:0] req_tx_count,
   input  logic [7:0] req_rx_size,
   input  logic       req_arb_lost,
   input  logic       req_acked,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_bus_cmd,
   output logic [7:0] rsp_cmd_byte,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_data,
   output logic [7:0] rsp_rx_index,
   output logic       rsp_done_res,
   output logic       rsp_check_error,
   output logic [7:0] rsp_rx_total
);

   item_type   front_item;
   item_type   head_item;
   logic       head_valid;
   logic       queue_full;
   logic       push;
   logic       pop;
   result_type result;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classification
   i2c_fts_front #(
      .TX_DEPTH (TX_DEPTH)
   ) u_front (
      .req_kind       (req_kind),
      .req_tx_byte    (req_tx_byte),
      .req_slave_addr (req_slave_addr),
      .req_tx_count   (req_tx_count),
      .req_rx_size    (req_rx_size),
      .req_arb_lost   (req_arb_lost),
      .req_acked      (req_acked),
      .req_rx_byte    (req_rx_byte),
      .item           (front_item)
   );

   // queue between front and back
   i2c_fts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .pop        (pop),
      .head_item  (head_item)
   );

   // sequencer
   i2c_fts_back #(
      .TX_DEPTH (TX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_result (result)
   );

   // response fields
   assign rsp_bus_cmd     = result.bus_cmd;
   assign rsp_cmd_byte    = result.cmd_byte;
   assign rsp_rx_valid    = result.rx_valid;
   assign rsp_rx_data     = result.rx_data;
   assign rsp_rx_index    = result.rx_index;
   assign rsp_done_res    = result.done_res;
   assign rsp_check_error = result.check_error;
   assign rsp_rx_total    = result.rx_total;

endmodule

@@ sv/i2c_fts_front.sv @@
// front part: classifies request items and saturates the transmit count
// depends on i2c_fts_pkg

module i2c_fts_front
   import i2c_fts_pkg::*;
#(
   parameter int TX_DEPTH = 32
) (
   input  logic [1:0] req_kind,
   input  logic [7:0] req_tx_byte,
   input  logic [7:0] req_slave_addr,
   input  logic [5:0] req_tx_count,
   input  logic [7:0] req_rx_size,
   input  logic       req_arb_lost,
   input  logic       req_acked,
   input  logic [7:0] req_rx_byte,
   output item_type   item
);

   localparam logic [8:0] DEPTH_C = 9'(TX_DEPTH);

   // decode kind and clamp count to the store depth
   always_comb begin
      item.tx_byte    = req_tx_byte;
      item.slave_addr = req_slave_addr;
      item.rx_size    = req_rx_size;
      item.arb_lost   = req_arb_lost;
      item.acked      = req_acked;
      item.rx_byte    = req_rx_byte;
      if ({3'b000, req_tx_count} > DEPTH_C) begin
         item.tx_count = DEPTH_C[5:0];
      end else begin
         item.tx_count = req_tx_count;
      end
      case (req_kind)
         KIND_LOAD:  item.op = OP_LOAD;
         KIND_START: item.op = OP_START;
         KIND_EVENT: item.op = OP_EVENT;
         default:    item.op = OP_NOP;
      endcase
   end

endmodule

@@ sv/i2c_fts_queue.sv @@
// short queue of classified items between front and back: pointers and fill count
// depends on i2c_fts_pkg and i2c_fts_fifo

module i2c_fts_queue
   import i2c_fts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     head_valid,
   input  logic     pop,
   output item_type head_item
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [QUEUE_PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   i2c_fts_fifo u_fifo (
      .clock   (clock),
      .wr_en   (push),
      .wr_ptr  (wr_ptr_ff),
      .wr_item (push_item),
      .rd_ptr  (rd_ptr_ff),
      .rd_item (head_item)
   );

endmodule

@@ sv/i2c_fts_fifo.sv @@
// entry storage of the queue between front and back
// depends on i2c_fts_pkg

module i2c_fts_fifo
   import i2c_fts_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [QUEUE_PW-1:0] wr_ptr,
   input  item_type            wr_item,
   input  logic [QUEUE_PW-1:0] rd_ptr,
   output item_type            rd_item
);

   item_type entry_ff [QUEUE_DEPTH];

   assign rd_item = entry_ff[rd_ptr];

   // entry write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr] <= wr_item;
      end
   end

endmodule

@@ sv/i2c_fts_back.sv @@
// back part: transaction sequencer, transmit store and result register
// depends on i2c_fts_pkg

module i2c_fts_back
   import i2c_fts_pkg::*;
#(
   parameter int TX_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  item_type   head_item,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_result
);

   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int LW = $clog2(TX_DEPTH + 1);
   localparam logic [8:0] DEPTH_C = 9'(TX_DEPTH);

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic        write_mode_ff, write_mode_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  receive_limit_ff, receive_limit_in;
   logic [7:0]  running_check_ff, running_check_in;
   logic        awaiting_clock_ff, awaiting_clock_in;
   logic [7:0]  address_byte_ff, address_byte_in;
   logic [5:0]  send_count_ff, send_count_in;
   logic [7:0]  receive_size_ff, receive_size_in;
   logic        mismatch_ff, mismatch_in;
   logic [LW-1:0] load_pointer_ff, load_pointer_in;

   // transmit store
   logic [7:0]  store_mem [TX_DEPTH];
   logic [7:0]  store_rd_ff;
   logic        store_we;
   logic [AW-1:0] store_wa;
   logic [AW-1:0] store_ra;

   // result register
   logic        out_valid_ff, out_valid_in;
   result_type  out_result_ff;
   result_type  result;
   logic        out_load;

   logic        busy;
   logic [7:0]  bi_inc;
   logic        store_room;

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;
   assign out_load   = !out_valid_ff || !out_stall;
   assign pop        = head_valid && out_load;
   assign busy       = (phase_ff != PH_IDLE) && (phase_ff != PH_DONE);
   assign bi_inc     = byte_index_ff + 8'd1;
   assign store_room = (load_pointer_ff < LW'(TX_DEPTH));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (pop) begin
         case (head_item.op)
            OP_START: begin
               if (!busy) begin
                  phase_in = PH_ADDR;
               end
            end
            OP_EVENT: begin
               case (phase_ff)
                  PH_ADDR: begin
                     if (!head_item.arb_lost) begin
                        phase_in = write_mode_ff ? PH_LEN : PH_RXSTART;
                     end
                  end
                  PH_LEN, PH_DATA, PH_CHK, PH_SENT: begin
                     if (head_item.arb_lost) begin
                        phase_in = PH_ADDR;
                     end else if (head_item.acked && phase_ff != PH_SENT) begin
                        if (phase_ff == PH_LEN) begin
                           phase_in = (send_count_ff != '0) ? PH_DATA : PH_CHK;
                        end else if (phase_ff == PH_DATA) begin
                           if (bi_inc >= {2'b00, send_count_ff}) begin
                              phase_in = PH_CHK;
                           end
                        end else begin
                           phase_in = PH_SENT;
                        end
                     end else if (receive_size_ff != '0) begin
                        phase_in = PH_ADDR;
                     end else begin
                        phase_in = PH_WAITSTOP;
                     end
                  end
                  PH_RXSTART: begin
                     phase_in = head_item.acked ? PH_RXLEN : PH_WAITSTOP;
                  end
                  PH_RXLEN: begin
                     if (head_item.rx_byte != '0 && receive_size_ff != '0) begin
                        phase_in = PH_RXDATA;
                     end else begin
                        phase_in = PH_RXCHK;
                     end
                  end
                  PH_RXDATA: begin
                     if (!awaiting_clock_ff && bi_inc >= receive_limit_ff) begin
                        phase_in = PH_RXCHK;
                     end
                  end
                  PH_RXCHK: begin
                     if (!awaiting_clock_ff) begin
                        phase_in = PH_WAITSTOP;
                     end
                  end
                  PH_WAITSTOP: phase_in = PH_DONE;
                  default:     phase_in = phase_ff;
               endcase
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // datapath and result for the item at the queue head
   always_comb begin
      write_mode_in     = write_mode_ff;
      byte_index_in     = byte_index_ff;
      receive_limit_in  = receive_limit_ff;
      running_check_in  = running_check_ff;
      awaiting_clock_in = awaiting_clock_ff;
      address_byte_in   = address_byte_ff;
      send_count_in     = send_count_ff;
      receive_size_in   = receive_size_ff;
      mismatch_in       = mismatch_ff;
      load_pointer_in   = load_pointer_ff;
      store_we          = 1'b0;
      store_wa          = load_pointer_ff[AW-1:0];
      result            = '0;
      result.bus_cmd    = CMD_NONE;
      if (pop) begin
         case (head_item.op)
            OP_LOAD: begin
               if (!busy && store_room) begin
                  store_we        = 1'b1;
                  load_pointer_in = load_pointer_ff + 1'b1;
               end
            end
            OP_START: begin
               if (!busy) begin
                  address_byte_in   = head_item.slave_addr;
                  send_count_in     = head_item.tx_count;
                  receive_size_in   = head_item.rx_size;
                  write_mode_in     = (head_item.tx_count != '0);
                  mismatch_in       = 1'b0;
                  awaiting_clock_in = 1'b0;
                  byte_index_in     = '0;
                  receive_limit_in  = '0;
                  running_check_in  = '0;
                  load_pointer_in   = '0;
                  result.bus_cmd    = CMD_START;
               end
            end
            OP_EVENT: begin
               case (phase_ff)
                  PH_ADDR: begin
                     if (head_item.arb_lost) begin
                        result.bus_cmd = CMD_START;
                     end else begin
                        result.bus_cmd   = CMD_SEND;
                        result.cmd_byte  = address_byte_ff | {7'd0, !write_mode_ff};
                        byte_index_in    = '0;
                        running_check_in = address_byte_ff;
                     end
                  end
                  PH_LEN, PH_DATA, PH_CHK, PH_SENT: begin
                     if (head_item.arb_lost) begin
                        result.bus_cmd = CMD_START;
                     end else if (head_item.acked && phase_ff != PH_SENT) begin
                        result.bus_cmd = CMD_SEND;
                        if (phase_ff == PH_LEN) begin
                           result.cmd_byte  = {2'b00, send_count_ff};
                           running_check_in = running_check_ff + {2'b00, send_count_ff};
                        end else if (phase_ff == PH_DATA) begin
                           result.cmd_byte  = store_rd_ff;
                           byte_index_in    = bi_inc;
                           running_check_in = running_check_ff + store_rd_ff;
                        end else begin
                           result.cmd_byte = running_check_ff;
                        end
                     end else if (receive_size_ff != '0) begin
                        result.bus_cmd = CMD_RESTART;
                        write_mode_in  = 1'b0;
                     end else begin
                        result.bus_cmd = CMD_STOP;
                     end
                  end
                  PH_RXSTART: begin
                     result.bus_cmd = head_item.acked ? CMD_CLOCK : CMD_STOP;
                  end
                  PH_RXLEN: begin
                     if (head_item.rx_byte < receive_size_ff) begin
                        receive_limit_in = head_item.rx_byte;
                     end else begin
                        receive_limit_in = receive_size_ff;
                     end
                     running_check_in  = running_check_ff + head_item.rx_byte;
                     result.bus_cmd    = CMD_ACK;
                     awaiting_clock_in = 1'b1;
                  end
                  PH_RXDATA: begin
                     if (awaiting_clock_ff) begin
                        result.bus_cmd    = CMD_CLOCK;
                        awaiting_clock_in = 1'b0;
                     end else begin
                        result.bus_cmd    = CMD_ACK;
                        result.rx_valid   = 1'b1;
                        result.rx_data    = head_item.rx_byte;
                        result.rx_index   = byte_index_ff;
                        byte_index_in     = bi_inc;
                        running_check_in  = running_check_ff + head_item.rx_byte;
                        awaiting_clock_in = 1'b1;
                     end
                  end
                  PH_RXCHK: begin
                     if (awaiting_clock_ff) begin
                        result.bus_cmd    = CMD_CLOCK;
                        awaiting_clock_in = 1'b0;
                     end else begin
                        if (head_item.rx_byte != running_check_ff) begin
                           mismatch_in = 1'b1;
                        end
                        result.bus_cmd = CMD_STOP;
                     end
                  end
                  PH_WAITSTOP: begin
                     result.done_res    = 1'b1;
                     result.check_error = mismatch_ff;
                     result.rx_total    = write_mode_ff ? 8'd0 : byte_index_ff;
                  end
                  default: result.bus_cmd = CMD_NONE;
               endcase
            end
            default: result.bus_cmd = CMD_NONE;
         endcase
      end
   end

   // store read address follows the next byte index, kept inside the depth
   always_comb begin
      if ({1'b0, byte_index_in} < DEPTH_C) begin
         store_ra = byte_index_in[AW-1:0];
      end else begin
         store_ra = '0;
      end
   end

   // result register handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = head_valid;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         write_mode_ff     <= 1'b0;
         byte_index_ff     <= '0;
         receive_limit_ff  <= '0;
         running_check_ff  <= '0;
         awaiting_clock_ff <= 1'b0;
         address_byte_ff   <= '0;
         send_count_ff     <= '0;
         receive_size_ff   <= '0;
         mismatch_ff       <= 1'b0;
         load_pointer_ff   <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         write_mode_ff     <= write_mode_in;
         byte_index_ff     <= byte_index_in;
         receive_limit_ff  <= receive_limit_in;
         running_check_ff  <= running_check_in;
         awaiting_clock_ff <= awaiting_clock_in;
         address_byte_ff   <= address_byte_in;
         send_count_ff     <= send_count_in;
         receive_size_ff   <= receive_size_in;
         mismatch_ff       <= mismatch_in;
         load_pointer_ff   <= load_pointer_in;
         out_valid_ff      <= out_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         out_result_ff <= result;
      end
   end

   // transmit store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_wa] <= head_item.tx_byte;
      end
      store_rd_ff <= store_mem[store_ra];
   end

endmodule

@@ tb/i2c_framed_transfer_sequencer_tb.sv @@
// self-checking testbench for the i2c framed-transfer sequencer
// depends on i2c_fts_pkg and i2c_framed_transfer_sequencer
// a small tracker class mirrors the sequencer and checks each response in order

module i2c_framed_transfer_sequencer_tb
   import i2c_fts_pkg::*;
();

   localparam int         STORE_DEPTH   = 32;
   localparam int         RANDOM_ITEMS  = 860;
   localparam int         CYCLE_LIMIT   = 600000;
   localparam int         REPORT_LIMIT  = 10;
   localparam int         PRESSURE_HOLD = 80;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;

   // one request as offered on the input side
   typedef struct {
      logic [1:0] kind;
      logic [7:0] tx_byte;
      logic [7:0] slave_addr;
      logic [5:0] tx_count;
      logic [7:0] rx_size;
      logic       arb_lost;
      logic       acked;
      logic [7:0] rx_byte;
   } req_item_type;

   // mirror of the sequencer state plus the responses still due
   class command_tracker_type;
      phase_type  ph;
      bit         wr_mode;
      bit [7:0]   byte_pos;
      bit [7:0]   rx_limit;
      bit [7:0]   csum;
      bit         await_clk;
      bit [7:0]   addr;
      bit [5:0]   n_send;
      bit [7:0]   rx_size;
      bit         csum_err;
      bit [5:0]   ld_ptr;
      bit [7:0]   tx_store [STORE_DEPTH];
      int         loaded_len;
      result_type due_responses [$];
      int         failures;
      int         checked;
      int         dones;
      int         rx_bytes;
      int         flagged;

      function new();
         ph         = PH_IDLE;
         wr_mode    = 1'b0;
         byte_pos   = '0;
         rx_limit   = '0;
         csum       = '0;
         await_clk  = 1'b0;
         addr       = '0;
         n_send     = '0;
         rx_size    = '0;
         csum_err   = 1'b0;
         ld_ptr     = '0;
         loaded_len = 0;
         failures   = 0;
         checked    = 0;
         dones      = 0;
         rx_bytes   = 0;
         flagged    = 0;
      endfunction

      function bit busy();
         return ph != PH_IDLE && ph != PH_DONE;
      endfunction

      // one bus event moves the sequence on by one command
      function void step_bus(req_item_type r, inout result_type res);
         bit [7:0] b;
         case (ph)
            PH_ADDR: begin
               if (r.arb_lost) begin
                  res.bus_cmd = CMD_START;
               end else begin
                  res.bus_cmd  = CMD_SEND;
                  res.cmd_byte = addr | {7'd0, ~wr_mode};
                  byte_pos     = '0;
                  csum         = addr;
                  ph           = wr_mode ? PH_LEN : PH_RXSTART;
               end
            end
            PH_LEN, PH_DATA, PH_CHK, PH_SENT: begin
               if (r.arb_lost) begin
                  res.bus_cmd = CMD_START;
                  ph          = PH_ADDR;
               end else if (r.acked && ph != PH_SENT) begin
                  res.bus_cmd = CMD_SEND;
                  if (ph == PH_LEN) begin
                     b    = {2'b00, n_send};
                     csum = csum + b;
                     ph   = (n_send > 0) ? PH_DATA : PH_CHK;
                  end else if (ph == PH_DATA) begin
                     b        = (byte_pos < STORE_DEPTH) ? tx_store[byte_pos] : 8'h00;
                     byte_pos = byte_pos + 8'd1;
                     csum     = csum + b;
                     if (byte_pos >= n_send) ph = PH_CHK;
                  end else begin
                     b  = csum;
                     ph = PH_SENT;
                  end
                  res.cmd_byte = b;
               end else if (rx_size != 0) begin
                  res.bus_cmd = CMD_RESTART;
                  wr_mode     = 1'b0;
                  ph          = PH_ADDR;
               end else begin
                  res.bus_cmd = CMD_STOP;
                  ph          = PH_WAITSTOP;
               end
            end
            PH_RXSTART: begin
               if (r.acked) begin
                  res.bus_cmd = CMD_CLOCK;
                  ph          = PH_RXLEN;
               end else begin
                  res.bus_cmd = CMD_STOP;
                  ph          = PH_WAITSTOP;
               end
            end
            PH_RXLEN: begin
               rx_limit    = (r.rx_byte < rx_size) ? r.rx_byte : rx_size;
               csum        = csum + r.rx_byte;
               res.bus_cmd = CMD_ACK;
               await_clk   = 1'b1;
               ph          = (rx_limit > 0) ? PH_RXDATA : PH_RXCHK;
            end
            PH_RXDATA: begin
               if (await_clk) begin
                  res.bus_cmd = CMD_CLOCK;
                  await_clk   = 1'b0;
               end else begin
                  res.bus_cmd  = CMD_ACK;
                  res.rx_valid = 1'b1;
                  res.rx_data  = r.rx_byte;
                  res.rx_index = byte_pos;
                  byte_pos     = byte_pos + 8'd1;
                  csum         = csum + r.rx_byte;
                  await_clk    = 1'b1;
                  if (byte_pos >= rx_limit) ph = PH_RXCHK;
               end
            end
            PH_RXCHK: begin
               if (await_clk) begin
                  res.bus_cmd = CMD_CLOCK;
                  await_clk   = 1'b0;
               end else begin
                  if (r.rx_byte != csum) csum_err = 1'b1;
                  res.bus_cmd = CMD_STOP;
                  ph          = PH_WAITSTOP;
               end
            end
            PH_WAITSTOP: begin
               ph              = PH_DONE;
               res.done_res    = 1'b1;
               res.check_error = csum_err;
               res.rx_total    = wr_mode ? 8'd0 : byte_pos;
            end
            default: ;
         endcase
      endfunction

      // work out the response to an accepted request
      function void note_request(req_item_type r);
         result_type res;
         bit [5:0]   n;
         res = '0;
         case (r.kind)
            KIND_LOAD: begin
               if (!busy() && ld_ptr < STORE_DEPTH) begin
                  tx_store[ld_ptr] = r.tx_byte;
                  ld_ptr = ld_ptr + 6'd1;
                  if (ld_ptr > loaded_len) loaded_len = ld_ptr;
               end
            end
            KIND_START: begin
               if (!busy()) begin
                  n           = (r.tx_count > STORE_DEPTH) ? 6'(STORE_DEPTH) : r.tx_count;
                  addr        = r.slave_addr;
                  n_send      = n;
                  rx_size     = r.rx_size;
                  wr_mode     = (n != 0);
                  csum_err    = 1'b0;
                  await_clk   = 1'b0;
                  byte_pos    = '0;
                  rx_limit    = '0;
                  csum        = '0;
                  ld_ptr      = '0;
                  ph          = PH_ADDR;
                  res.bus_cmd = CMD_START;
               end
            end
            KIND_EVENT: step_bus(r, res);
            default: ;
         endcase
         due_responses.push_back(res);
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("mismatch %0d: %s", failures, msg);
      endfunction

      // compare a response with the oldest one due
      function void check_response(result_type got);
         result_type want;
         bit         bad;
         if (due_responses.size() == 0) begin
            report($sformatf("response with none due: cmd %0d byte %02h", got.bus_cmd,
                             got.cmd_byte));
            return;
         end
         want = due_responses.pop_front();
         checked++;
         bad = (got.bus_cmd !== want.bus_cmd) || (got.cmd_byte !== want.cmd_byte) ||
               (got.rx_valid !== want.rx_valid) || (got.rx_data !== want.rx_data) ||
               (got.rx_index !== want.rx_index) || (got.done_res !== want.done_res) ||
               (got.check_error !== want.check_error) || (got.rx_total !== want.rx_total);
         if (bad)
            report($sformatf({"response %0d exp cmd %0d byte %02h rxv %0b data %02h idx %0d ",
                              "done %0b err %0b total %0d, got cmd %0d byte %02h rxv %0b ",
                              "data %02h idx %0d done %0b err %0b total %0d"},
                             checked, want.bus_cmd, want.cmd_byte, want.rx_valid,
                             want.rx_data, want.rx_index, want.done_res, want.check_error,
                             want.rx_total, got.bus_cmd, got.cmd_byte, got.rx_valid,
                             got.rx_data, got.rx_index, got.done_res, got.check_error,
                             got.rx_total));
         if (want.done_res) dones++;
         if (want.rx_valid) rx_bytes++;
         if (want.check_error) flagged++;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_kind;
   logic [7:0] req_tx_byte;
   logic [7:0] req_slave_addr;
   logic [5:0] req_tx_count;
   logic [7:0] req_rx_size;
   logic       req_arb_lost;
   logic       req_acked;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_bus_cmd;
   logic [7:0] rsp_cmd_byte;
   logic       rsp_rx_valid;
   logic [7:0] rsp_rx_data;
   logic [7:0] rsp_rx_index;
   logic       rsp_done_res;
   logic       rsp_check_error;
   logic [7:0] rsp_rx_total;

   command_tracker_type tracker;
   int                  sent_count       = 0;
   int                  cycle_count      = 0;
   bit                  pressure_pending = 1'b0;

   i2c_framed_transfer_sequencer #(
      .TX_DEPTH(STORE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_tx_byte    (req_tx_byte),
      .req_slave_addr (req_slave_addr),
      .req_tx_count   (req_tx_count),
      .req_rx_size    (req_rx_size),
      .req_arb_lost   (req_arb_lost),
      .req_acked      (req_acked),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_bus_cmd    (rsp_bus_cmd),
      .rsp_cmd_byte   (rsp_cmd_byte),
      .rsp_rx_valid   (rsp_rx_valid),
      .rsp_rx_data    (rsp_rx_data),
      .rsp_rx_index   (rsp_rx_index),
      .rsp_done_res   (rsp_done_res),
      .rsp_check_error(rsp_check_error),
      .rsp_rx_total   (rsp_rx_total)
   );

   // clock
   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic req_item_type req(logic [1:0] kind, logic [7:0] txb, logic [7:0] sa,
                                        logic [5:0] cnt, logic [7:0] rxs, bit arb, bit ack,
                                        logic [7:0] rxb);
      req_item_type r;
      r.kind       = kind;
      r.tx_byte    = txb;
      r.slave_addr = sa;
      r.tx_count   = cnt;
      r.rx_size    = rxs;
      r.arb_lost   = arb;
      r.acked      = ack;
      r.rx_byte    = rxb;
      return r;
   endfunction

   function automatic req_item_type noise_item();
      return req(2'($urandom), 8'($urandom), 8'($urandom), 6'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom), 8'($urandom));
   endfunction

   // bus event that suits the current phase, with occasional faults
   function automatic req_item_type next_event(bit big);
      req_item_type r;
      r      = noise_item();
      r.kind = KIND_EVENT;
      case (tracker.ph)
         PH_ADDR: r.arb_lost = ($urandom_range(0, 9) == 0);
         PH_LEN, PH_DATA, PH_CHK: begin
            r.arb_lost = ($urandom_range(0, 19) == 0);
            r.acked    = ($urandom_range(0, 11) != 0);
         end
         PH_SENT: r.arb_lost = ($urandom_range(0, 19) == 0);
         PH_RXSTART: r.acked = big || ($urandom_range(0, 9) != 0);
         PH_RXLEN: r.rx_byte = big ? 8'hFF : 8'($urandom_range(0, 10));
         PH_RXCHK: if ($urandom_range(0, 4) != 0) r.rx_byte = tracker.csum;
         default: ;
      endcase
      return r;
   endfunction

   // offer one request and hold it until the transfer, then maybe pause
   task automatic send_request(input req_item_type r);
      int pick;
      int gap;
      req_valid      <= 1'b1;
      req_kind       <= r.kind;
      req_tx_byte    <= r.tx_byte;
      req_slave_addr <= r.slave_addr;
      req_tx_count   <= r.tx_count;
      req_rx_size    <= r.rx_size;
      req_arb_lost   <= r.arb_lost;
      req_acked      <= r.acked;
      req_rx_byte    <= r.rx_byte;
      do begin
         @(posedge clock);
      end while (req_stall);
      tracker.note_request(r);
      sent_count++;
      @(negedge clock);
      pick = $urandom_range(0, 99);
      if (pick < 75) gap = 0;
      else if (pick < 96) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 25);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // loads, a start, then bus events until the transaction is finished
   task automatic run_transaction(input bit big);
      req_item_type r;
      int           nload;
      int           n;
      int           pick;
      nload = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
      repeat (nload) begin
         r      = noise_item();
         r.kind = KIND_LOAD;
         send_request(r);
      end
      // only stored bytes may be sent
      r                = noise_item();
      r.kind           = KIND_START;
      r.slave_addr[0]  = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 5) == 0) n = tracker.loaded_len;
      else n = $urandom_range(0, tracker.loaded_len);
      if (n == STORE_DEPTH && $urandom_range(0, 1)) n = $urandom_range(33, 63);
      r.tx_count = 6'(n);
      pick = $urandom_range(0, 99);
      if (big) r.rx_size = 8'hFF;
      else if (pick < 40) r.rx_size = 8'd0;
      else if (pick < 85) r.rx_size = 8'($urandom_range(1, 8));
      else r.rx_size = 8'($urandom_range(9, 255));
      send_request(r);
      // a stray load or start while busy now and then
      while (tracker.ph != PH_DONE) begin
         if ($urandom_range(0, 24) == 0) send_request(noise_item());
         else send_request(next_event(big));
      end
   endtask

   // response side: check each transfer, stall in random runs
   initial begin : response_side
      int         quiet_left;
      int         stall_left;
      int         hold_left;
      int         pick;
      result_type got;
      quiet_left = 0;
      stall_left = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.bus_cmd     = cmd_type'(rsp_bus_cmd);
            got.cmd_byte    = rsp_cmd_byte;
            got.rx_valid    = rsp_rx_valid;
            got.rx_data     = rsp_rx_data;
            got.rx_index    = rsp_rx_index;
            got.done_res    = rsp_done_res;
            got.check_error = rsp_check_error;
            got.rx_total    = rsp_rx_total;
            tracker.check_response(got);
         end
         if (pressure_pending) begin
            pressure_pending = 1'b0;
            hold_left        = PRESSURE_HOLD;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (quiet_left > 0) begin
            quiet_left--;
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               quiet_left = $urandom_range(0, 19);
               rsp_stall <= 1'b0;
            end else if (pick < 95) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else begin
               stall_left = $urandom_range(9, 29);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // request side: reset, directed sequence, random transactions, drain
   initial begin : request_side
      req_item_type r;
      int           directed_count;
      tracker        = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_LOAD;
      req_tx_byte    = '0;
      req_slave_addr = '0;
      req_tx_count   = '0;
      req_rx_size    = '0;
      req_arb_lost   = 1'b0;
      req_acked      = 1'b0;
      req_rx_byte    = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // event while idle and an unknown kind, both ignored
      send_request(req(KIND_EVENT, 8'hFF, 8'hFF, 6'h3F, 8'hFF, 1'b1, 1'b1, 8'hFF));
      send_request(req(KIND_UNUSED, 8'hFF, 8'hFF, 6'h3F, 8'hFF, 1'b1, 1'b1, 8'hFF));
      // transmit bytes at both extremes
      send_request(req(KIND_LOAD, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0, 8'h00));
      send_request(req(KIND_LOAD, 8'hFF, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0, 8'h00));
      // write two bytes, then read up to two
      send_request(req(KIND_START, 8'h00, 8'hFE, 6'd2, 8'd2, 1'b0, 1'b0, 8'h00));
      // load and start while busy are dropped
      send_request(req(KIND_LOAD, 8'hA5, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0, 8'h00));
      send_request(req(KIND_START, 8'h00, 8'h10, 6'd63, 8'd0, 1'b0, 1'b0, 8'h00));
      // address, length, two data bytes, check byte
      repeat (5) send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      // no ack after the frame turns the bus round to read
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b0, 8'h00));
      // arbitration lost on the read address, then resent
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b1, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      // received length above the receive size is capped
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'd5));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'hFF));
      // wrong check byte, then completion
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      send_request(req(KIND_EVENT, 8'h00, 8'h00, 6'd0, 8'd0, 1'b0, 1'b1, 8'h00));
      directed_count = sent_count;

      // long receiver hold-off while a full-length read streams in
      pressure_pending = 1'b1;
      run_transaction(1'b1);
      while (sent_count < directed_count + RANDOM_ITEMS) begin
         if ($urandom_range(0, 5) == 0) begin
            r      = noise_item();
            r.kind = $urandom_range(0, 1) ? KIND_EVENT : KIND_UNUSED;
            send_request(r);
         end
         run_transaction(1'b0);
      end

      // drain
      req_valid <= 1'b0;
      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("run covered %0d request transfers and %0d checked responses", sent_count,
               tracker.checked);
      $display("%0d transactions completed, %0d bytes delivered, %0d check errors flagged",
               tracker.dones, tracker.rx_bytes, tracker.flagged);
      if (tracker.failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ i2c_framed_transfer_sequencer.f @@
sv/i2c_fts_pkg.sv
sv/i2c_fts_front.sv
sv/i2c_fts_queue.sv
sv/i2c_fts_fifo.sv
sv/i2c_fts_back.sv
sv/i2c_framed_transfer_sequencer.sv
tb/i2c_framed_transfer_sequencer_tb.sv
